@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: invariant");

`endif

@@ hdl/scsc_pkg.sv @@
// ----------------------------------------------------------------------------
// scsc_pkg
// Types and constants shared by the supercover segment check block.
// ----------------------------------------------------------------------------
`default_nettype none

package scsc_pkg;

	localparam int GRID_SIZE = 64;
	localparam int ROW_W     = 64;
	localparam int COORD_W   = 6;
	localparam int STEP_W    = 7;
	localparam int CROSS_W   = 2 * COORD_W + 1;

	// rows that can be addressed by a 6-bit index and lie inside the grid
	localparam int MAP_ROWS  = (GRID_SIZE < (1 << COORD_W)) ? GRID_SIZE : (1 << COORD_W);
	localparam int ROW_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

	// columns at or beyond the grid edge always read as blocked
	localparam logic [ROW_W-1:0] COL_MASK =
		(GRID_SIZE >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << GRID_SIZE) - ROW_W'(1));

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 8;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_CHECK = 1'b1
	} cmd_code_t;

	typedef enum logic {
		KIND_ACK   = 1'b0,
		KIND_CHECK = 1'b1
	} kind_code_t;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [IN_DATA_W-ROW_W-5*COORD_W-1:0] pad;
		logic [COORD_W-1:0]                   end_y;
		logic [COORD_W-1:0]                   end_x;
		logic [COORD_W-1:0]                   start_y;
		logic [COORD_W-1:0]                   start_x;
		logic [ROW_W-1:0]                     row_bits;
		logic [COORD_W-1:0]                   row_index;
	} in_item_t;

	typedef struct packed {
		logic [STEP_W-1:0] steps_walked;
		logic              safe;
	} out_item_t;

	typedef struct packed {
		logic load_seg;   // latch a segment, read both end rows
		logic wr_row;     // write one map row
		logic step;       // advance the walker one cell
		logic res_chk;    // capture the check answer
		logic res_ack;    // capture a write acknowledge
		logic out_load;   // move the held answer to the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic more;       // walker has not reached the end cell
		logic fail;       // cell check in flight found a blocked cell
		logic out_free;   // output register can take an answer
	} dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/scsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// scsc_ctrl
// Sequencer: takes requests, runs the walk, hands answers to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module scsc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	input  wire                   s_tuser,
	output logic                  s_tready,
	input  wire scsc_pkg::dp_sts_t sts,
	output scsc_pkg::ctrl_cmd_t   cmd
);
	import scsc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   ready_q;
	logic   accept;

	assign s_tready = ready_q;
	assign accept   = s_tvalid && ready_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == CMD_WRITE) begin
						cmd.wr_row  = 1'b1;
						cmd.res_ack = 1'b1;
						state_nxt   = ST_RESP;
					end else begin
						cmd.load_seg = 1'b1;
						state_nxt    = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (sts.fail || !sts.more) begin
					cmd.res_chk = 1'b1;
					state_nxt   = ST_RESP;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_nxt;
			ready_q <= (state_nxt == ST_IDLE);
		end
	end

endmodule

`default_nettype wire

@@ hdl/scsc_dpath.sv @@
// ----------------------------------------------------------------------------
// scsc_dpath
// Occupancy map, supercover walker, cell check stage and answer registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scsc_dpath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  [scsc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire  scsc_pkg::ctrl_cmd_t           cmd,
	output scsc_pkg::dp_sts_t                   sts,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [scsc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser
);
	import scsc_pkg::*;

	in_item_t item;
	assign item = in_item_t'(s_tdata);

	// ---------------- occupancy map ----------------
	logic [ROW_W-1:0] mem [MAP_ROWS];
	logic [MAP_ROWS-1:0] row_vld_q;

	logic [COORD_W-1:0] addr_a;
	logic [COORD_W-1:0] addr_b;
	logic               wr_in_range;
	logic               a_in_range;
	logic               b_in_range;
	logic [ROW_W-1:0]   rda_s1;
	logic [ROW_W-1:0]   rdb_s1;
	logic               rda_vld_s1;
	logic               rdb_vld_s1;

	assign wr_in_range = {1'b0, item.row_index} < (COORD_W+1)'(MAP_ROWS);
	assign a_in_range  = {1'b0, addr_a} < (COORD_W+1)'(MAP_ROWS);
	assign b_in_range  = {1'b0, addr_b} < (COORD_W+1)'(MAP_ROWS);

	always_ff @(posedge clk) begin
		if (cmd.wr_row && wr_in_range)
			mem[item.row_index[ROW_AW-1:0]] <= item.row_bits & COL_MASK;
		rda_s1 <= mem[addr_a[ROW_AW-1:0]];
		rdb_s1 <= mem[addr_b[ROW_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			rda_vld_s1 <= 1'b0;
			rdb_vld_s1 <= 1'b0;
		end else begin
			if (cmd.wr_row && wr_in_range)
				row_vld_q[item.row_index[ROW_AW-1:0]] <= 1'b1;
			rda_vld_s1 <= a_in_range && row_vld_q[addr_a[ROW_AW-1:0]];
			rdb_vld_s1 <= b_in_range && row_vld_q[addr_b[ROW_AW-1:0]];
		end
	end

	// ---------------- walker ----------------
	logic [COORD_W-1:0] x_q, y_q, ix_q, iy_q, nx_q, ny_q;
	logic               x_neg_q, y_neg_q;
	logic [CROSS_W-1:0] cx_q, cy_q;
	logic [STEP_W-1:0]  step_q;

	logic               x_neg_in, y_neg_in;
	logic [COORD_W-1:0] nx_in, ny_in;
	logic               mv_x, mv_y;
	logic [COORD_W-1:0] x_nxt, y_nxt;

	assign x_neg_in = item.end_x < item.start_x;
	assign y_neg_in = item.end_y < item.start_y;
	assign nx_in    = x_neg_in ? item.start_x - item.end_x : item.end_x - item.start_x;
	assign ny_in    = y_neg_in ? item.start_y - item.end_y : item.end_y - item.start_y;

	always_comb begin
		mv_x = 1'b0;
		mv_y = 1'b0;
		if (ix_q == nx_q)
			mv_y = 1'b1;
		else if (iy_q == ny_q)
			mv_x = 1'b1;
		else if (cx_q < cy_q)
			mv_x = 1'b1;
		else if (cy_q < cx_q)
			mv_y = 1'b1;
		else begin
			// exact corner: diagonal step, both side cells checked
			mv_x = 1'b1;
			mv_y = 1'b1;
		end
		x_nxt = !mv_x ? x_q : (x_neg_q ? x_q - COORD_W'(1) : x_q + COORD_W'(1));
		y_nxt = !mv_y ? y_q : (y_neg_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1));
	end

	assign addr_a = cmd.load_seg ? item.start_y : y_nxt;
	assign addr_b = cmd.load_seg ? item.end_y   : y_q;

	always_ff @(posedge clk) begin
		if (cmd.load_seg) begin
			x_q     <= item.start_x;
			y_q     <= item.start_y;
			ix_q    <= '0;
			iy_q    <= '0;
			nx_q    <= nx_in;
			ny_q    <= ny_in;
			x_neg_q <= x_neg_in;
			y_neg_q <= y_neg_in;
			cx_q    <= CROSS_W'(ny_in);
			cy_q    <= CROSS_W'(nx_in);
			step_q  <= '0;
		end else if (cmd.step) begin
			x_q    <= x_nxt;
			y_q    <= y_nxt;
			ix_q   <= ix_q + COORD_W'(mv_x);
			iy_q   <= iy_q + COORD_W'(mv_y);
			cx_q   <= mv_x ? cx_q + CROSS_W'({ny_q, 1'b0}) : cx_q;
			cy_q   <= mv_y ? cy_q + CROSS_W'({nx_q, 1'b0}) : cy_q;
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign sts.more = (ix_q != nx_q) || (iy_q != ny_q);

	// ---------------- cell check stage ----------------
	// port A: row of the entered cell, start row on load; port B: previous row (corner side), end row on load
	logic [COORD_W-1:0] ca_s1, cb_s1, cc_s1;
	logic               need_b_s1, need_c_s1, chk_vld_s1;
	logic [STEP_W-1:0]  step_s1;
	logic               chk_ok;

	always_ff @(posedge clk) begin
		if (cmd.load_seg) begin
			ca_s1     <= item.start_x;
			cb_s1     <= item.end_x;
			cc_s1     <= item.start_x;
			need_b_s1 <= 1'b1;
			need_c_s1 <= 1'b0;
			step_s1   <= '0;
		end else if (cmd.step) begin
			ca_s1     <= x_nxt;
			cb_s1     <= x_nxt;
			cc_s1     <= x_q;
			need_b_s1 <= mv_x && mv_y;
			need_c_s1 <= mv_x && mv_y;
			step_s1   <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chk_vld_s1 <= 1'b0;
		else
			chk_vld_s1 <= cmd.load_seg || cmd.step;
	end

	assign chk_ok = rda_vld_s1 && rda_s1[ca_s1]
		&& (!need_b_s1 || (rdb_vld_s1 && rdb_s1[cb_s1]))
		&& (!need_c_s1 || rda_s1[cc_s1]);
	assign sts.fail = chk_vld_s1 && !chk_ok;

	// ---------------- answer hold and output register ----------------
	out_item_t res_q;
	logic      res_kind_q;
	logic      out_vld_q;
	out_item_t out_q;
	logic      out_kind_q;

	always_ff @(posedge clk) begin
		if (cmd.res_chk) begin
			res_kind_q         <= KIND_CHECK;
			res_q.safe         <= chk_ok;
			res_q.steps_walked <= step_s1;
		end else if (cmd.res_ack) begin
			res_kind_q <= KIND_ACK;
			res_q      <= '0;
		end
		if (cmd.out_load) begin
			out_q      <= res_q;
			out_kind_q <= res_kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_load)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	assign sts.out_free = !out_vld_q || m_tready;
	assign m_tvalid     = out_vld_q;
	assign m_tdata      = out_q;
	assign m_tuser      = out_kind_q;

endmodule

`default_nettype wire

@@ hdl/supercover_segment_check.sv @@
// ----------------------------------------------------------------------------
// supercover_segment_check
// 64x64 passability map with a supercover line safety check between cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                                 | tuser
//  s_*     | in  | row_index[5:0] row_bits[69:6] start_x[75:70]          | cmd
//          |     | start_y[81:76] end_x[87:82] end_y[93:88] zero[95:94]  |
//  m_*     | out | safe[0] steps_walked[7:1]                             | kind
//
//  A row write goes through the answer hold and then the output register.
//  A check makes one map read per walked cell, the walker issuing a read
//  every cycle, with each read registered before the check stage sees it.
//  One request is in work at a time; a new one is taken while the previous
//  answer waits in the output register.
//  After reset every row reads as blocked; per-row valid bits make this
//  immediate, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module supercover_segment_check (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [scsc_pkg::IN_DATA_W-1:0]       s_tdata,   // row_index, row_bits, start_x,
	                                                        // start_y, end_x, end_y, pad
	input  wire                                  s_tuser,   // cmd
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [scsc_pkg::OUT_DATA_W-1:0]      m_tdata,   // safe, steps_walked
	output logic                                 m_tuser    // kind
);
	import scsc_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	scsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scsc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`ASSERT_ALWAYS(a_cmd_excl, $onehot0({cmd.load_seg, cmd.step, cmd.res_chk, cmd.out_load}))
	`ASSERT_SAME(a_step_more, cmd.step, sts.more)
	`ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	`ASSERT_SAME(a_ack_zero, m_tvalid && (m_tuser == KIND_ACK), m_tdata == '0)

endmodule

`default_nettype wire

@@ tb/supercover_segment_check_checker.sv @@
// ----------------------------------------------------------------------------
// supercover_segment_check_checker
// Watches both stream channels of the segment check block. Keeps its own copy
// of the passability map, walks the supercover line for every check request
// and compares each answer, field by field, with the oldest one expected.
// ----------------------------------------------------------------------------
module supercover_segment_check_checker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	input  wire                             s_tready,
	input  wire  [scsc_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire                             s_tuser,
	input  wire                             m_tvalid,
	input  wire                             m_tready,
	input  wire  [scsc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire                             m_tuser,
	output int                              mismatches,
	output int                              answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import scsc_pkg::*;

	typedef struct packed {
		kind_code_t        kind;
		logic              safe;
		logic [STEP_W-1:0] steps;
	} answer_t;

	answer_t          answers_due [$];
	logic [ROW_W-1:0] grid_rows [GRID_SIZE];

	task automatic report_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] seen);
		$display("%t checker: %s: expected %h, got %h", $realtime, what, want, seen);
		mismatches++;
	endtask

	function automatic logic cell_passable(input int x, input int y);
		if (x < 0 || y < 0 || x >= GRID_SIZE || y >= GRID_SIZE || x >= ROW_W)
			return 1'b0;
		return grid_rows[y][x];
	endfunction

	// supercover walk; the axis follows the smaller of the scaled crossings
	function automatic void trace_segment(input int x0, input int y0, input int x1,
		input int y1, output logic ok, output logic [STEP_W-1:0] count);
		int dx, dy, nx, ny, sx, sy, x, y, ix, iy, cx, cy, walked;
		dx = x1 - x0;
		dy = y1 - y0;
		nx = dx < 0 ? -dx : dx;
		ny = dy < 0 ? -dy : dy;
		sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
		sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
		x = x0;
		y = y0;
		ix = 0;
		iy = 0;
		walked = 0;
		ok = 1'b1;
		if (!cell_passable(x0, y0) || !cell_passable(x1, y1))
			ok = 1'b0;
		while (ok && (ix < nx || iy < ny)) begin
			walked++;
			if (ix == nx) begin
				y += sy;
				iy++;
			end else if (iy == ny) begin
				x += sx;
				ix++;
			end else begin
				cx = (1 + 2 * ix) * ny;
				cy = (1 + 2 * iy) * nx;
				if (cx < cy) begin
					x += sx;
					ix++;
				end else if (cy < cx) begin
					y += sy;
					iy++;
				end else if (!cell_passable(x + sx, y) || !cell_passable(x, y + sy)) begin
					// exact corner: both side cells have to be open
					ok = 1'b0;
				end else begin
					x += sx;
					y += sy;
					ix++;
					iy++;
				end
			end
			if (ok && !cell_passable(x, y))
				ok = 1'b0;
		end
		count = walked[STEP_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		in_item_t          req;
		out_item_t         got;
		answer_t           due;
		answer_t           fresh;
		logic              ok;
		logic [STEP_W-1:0] count;
		if (!arst_n) begin
			answers_due.delete();
			foreach (grid_rows[r])
				grid_rows[r] = '0;
			mismatches = 0;
			answers_pending = 0;
		end else begin
			// an answer never leaves in the cycle its own request is taken
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata);
				if (answers_due.size() == 0) begin
					report_mismatch("answer with no request in flight", '0,
						{m_tuser, m_tdata});
				end else begin
					due = answers_due.pop_front();
					if (m_tuser !== due.kind)
						report_mismatch("kind", due.kind, m_tuser);
					if (got.safe !== due.safe)
						report_mismatch("safe", due.safe, got.safe);
					if (got.steps_walked !== due.steps)
						report_mismatch("steps_walked", due.steps, got.steps_walked);
				end
			end
			if (s_tvalid && s_tready) begin
				req = in_item_t'(s_tdata);
				if (s_tuser == CMD_WRITE) begin
					if (int'(req.row_index) < GRID_SIZE)
						grid_rows[req.row_index] = req.row_bits;
					fresh.kind = KIND_ACK;
					fresh.safe = 1'b0;
					fresh.steps = '0;
				end else begin
					trace_segment(req.start_x, req.start_y, req.end_x, req.end_y, ok, count);
					fresh.kind = KIND_CHECK;
					fresh.safe = ok;
					fresh.steps = count;
				end
				answers_due = {answers_due, fresh};
			end
			answers_pending = answers_due.size();
		end
	end

endmodule

@@ tb/supercover_segment_check_tb.sv @@
// ----------------------------------------------------------------------------
// supercover_segment_check_tb
// Drives row writes and segment checks into the block: a directed opening
// over corner crossings, blocked ends and single-cell segments, then random
// maps and segments under four sender and receiver stall patterns. The
// checker beside the block predicts every answer and counts mismatches.
// ----------------------------------------------------------------------------
module supercover_segment_check_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scsc_pkg::*;

	localparam int COORD_MAX = (1 << COORD_W) - 1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	int                    mismatches;
	int                    answers_pending;
	int                    src_idle_pct;
	int                    sink_stall_pct;

	// rows as written so far; only used to aim checks at open cells
	logic [ROW_W-1:0] planned_rows [GRID_SIZE];

	supercover_segment_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	supercover_segment_check_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatches      (mismatches),
		.answers_pending (answers_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		#20ms;
		$display("supercover_segment_check_tb: done, errors");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_request(input cmd_code_t cmd, input in_item_t item);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			s_tuser = 1'($urandom_range(1));
			s_tdata = {$urandom, $urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = item;
		if (cmd == CMD_WRITE)
			planned_rows[item.row_index] = item.row_bits;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_row(input int idx, input logic [ROW_W-1:0] bits);
		in_item_t item;
		item = '0;
		item.row_index = idx[COORD_W-1:0];
		item.row_bits = bits;
		send_request(CMD_WRITE, item);
	endtask

	task automatic check_segment(input int x0, input int y0, input int x1, input int y1);
		in_item_t item;
		item = '0;
		item.start_x = x0[COORD_W-1:0];
		item.start_y = y0[COORD_W-1:0];
		item.end_x = x1[COORD_W-1:0];
		item.end_y = y1[COORD_W-1:0];
		send_request(CMD_CHECK, item);
	endtask

	task automatic hold_until_drained();
		s_tvalid = 1'b0;
		while (answers_pending != 0)
			@(negedge clk);
	endtask

	// mostly open rows so that long walks get through
	function automatic logic [ROW_W-1:0] random_row_bits();
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7:
				return ~({$urandom, $urandom} & {$urandom, $urandom}
					& {$urandom, $urandom} & {$urandom, $urandom});
			8, 9, 10, 11: return '1;
			12, 13, 14:   return {$urandom, $urandom};
			15:           return '0;
			16:           return ~(ROW_W'(1) << $urandom_range(ROW_W - 1));
			default:      return ~({$urandom, $urandom} & {$urandom, $urandom});
		endcase
	endfunction

	task automatic pick_open_cell(output int x, output int y);
		x = $urandom_range(COORD_MAX);
		y = $urandom_range(COORD_MAX);
		for (int t = 0; t < 32 && !planned_rows[y][x]; t++) begin
			x = $urandom_range(COORD_MAX);
			y = $urandom_range(COORD_MAX);
		end
	endtask

	task automatic run_phase(input int src_pct, input int sink_pct, input int count);
		int x0, y0, x1, y1, d;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int r = 0; r < GRID_SIZE; r++)
			write_row(r, random_row_bits());
		for (int i = GRID_SIZE; i < count; i++) begin
			if ($urandom_range(99) < 20) begin
				write_row($urandom_range(COORD_MAX), random_row_bits());
			end else begin
				if ($urandom_range(99) < 80) begin
					pick_open_cell(x0, y0);
				end else begin
					x0 = $urandom_range(COORD_MAX);
					y0 = $urandom_range(COORD_MAX);
				end
				case ($urandom_range(9))
					0, 1: begin
						x1 = x0 + int'($urandom_range(6)) - 3;
						y1 = y0 + int'($urandom_range(6)) - 3;
						x1 = x1 < 0 ? 0 : (x1 > COORD_MAX ? COORD_MAX : x1);
						y1 = y1 < 0 ? 0 : (y1 > COORD_MAX ? COORD_MAX : y1);
					end
					2: begin
						// equal spans give corner crossings at every step
						x1 = $urandom_range(COORD_MAX);
						d = x1 > x0 ? x1 - x0 : x0 - x1;
						y1 = (y0 + d <= COORD_MAX) ? y0 + d : y0 - d;
						if (y1 < 0)
							y1 = y0;
					end
					default: begin
						if ($urandom_range(99) < 80) begin
							pick_open_cell(x1, y1);
						end else begin
							x1 = $urandom_range(COORD_MAX);
							y1 = $urandom_range(COORD_MAX);
						end
					end
				endcase
				check_segment(x0, y0, x1, y1);
			end
		end
		hold_until_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		foreach (planned_rows[r])
			planned_rows[r] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_segment(0, 0, 0, 0);              // empty map, start blocked
		write_row(0, '1);
		check_segment(0, 0, 0, 0);              // single open cell
		check_segment(0, 0, COORD_MAX, 0);
		check_segment(COORD_MAX, 0, 0, 0);
		write_row(1, '1);
		check_segment(0, 0, 1, 1);              // corner, both sides open
		check_segment(COORD_MAX, 1, 0, 0);
		check_segment(5, 1, 5, 0);
		write_row(1, ~ROW_W'(1));
		check_segment(0, 0, 1, 1);              // corner, one side blocked
		check_segment(0, 0, 0, 5);              // end blocked
		check_segment(0, 5, 0, 0);              // start blocked
		write_row(COORD_MAX, {1'b1, {(ROW_W - 2){1'b0}}, 1'b1});
		check_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX);
		write_row(62, {(ROW_W / 2){2'b10}});
		write_row(32, {(ROW_W / 2){2'b01}});
		check_segment(1, 62, 3, 62);
		hold_until_drained();
		check_segment(0, 0, COORD_MAX, COORD_MAX);
		check_segment(0, COORD_MAX, COORD_MAX, 0);
		hold_until_drained();

		run_phase(0, 0, 500);
		run_phase(76, 0, 500);
		run_phase(0, 76, 500);
		run_phase(11, 11, 500);

		hold_until_drained();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && answers_pending == 0)
			$display("supercover_segment_check_tb: done, clean");
		else
			$display("supercover_segment_check_tb: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/scsc_pkg.sv
hdl/scsc_ctrl.sv
hdl/scsc_dpath.sv
hdl/supercover_segment_check.sv
tb/supercover_segment_check_checker.sv
tb/supercover_segment_check_tb.sv
